>>> src/mre_pkg.sv
// ============================================================================
// mre_pkg: shared constants and types of the recurrence term engine
// Holds the modulus, index width, matrix geometry and the tag that travels
// with each product through the modular multiply-accumulate unit.
// ============================================================================
`default_nettype none

package mre_pkg;

    // prime modulus and exponent width
    localparam int MODULUS    = 10007;
    localparam int INDEX_BITS = 32;

    // companion matrix geometry
    localparam int DIM       = 4;
    localparam int DIM_BITS  = $clog2(DIM);

    // residue and operand widths
    localparam int RES_BITS  = $clog2(MODULUS);
    localparam int RAW_BITS  = 16;
    localparam int OPW       = (RES_BITS > RAW_BITS) ? RES_BITS : RAW_BITS;
    localparam int VALUE_W   = 14;

    // matrix store: slot {is_base, bank}, then row, then column
    localparam int ADDR_BITS = 2 + 2 * DIM_BITS;

    // where a finished sum goes
    typedef enum logic [1:0] {
        DEST_MEM,
        DEST_COEF,
        DEST_OUT
    } dest_t;

    // tag carried alongside each product
    typedef struct packed {
        logic                 first;
        logic                 last;
        dest_t                dest;
        logic [ADDR_BITS-1:0] waddr;
    } mac_tag_t;

endpackage

`default_nettype wire

>>> src/modular_recurrence_nth_term_top.sv
// ============================================================================
// modular_recurrence_nth_term_top: nth term of a third-order recurrence mod p
// Raises the 4x4 companion matrix to the power n-2 by square-and-multiply,
// one modular product per cycle bar drain waits, via a shared multiply-accumulate unit.
// ============================================================================
//
// channel   dir  bits  contents
// s_*       in   80    term_index, coef_prev, coef_third_back, addend
// m_*       out  16    term_value
//
// an index below 3 answers zero; otherwise the setup writes all 32 matrix entries, the
// coefficients are reduced, then per exponent bit comes one squaring of 64 products plus
// pipeline drain, preceded by a multiply of 64 products on each set bit; the run time is
// set by the single multiply-accumulate unit and the two-read matrix store. reset is
// synchronous and active low; s_tready stays low while a word is worked on and while a
// finished word waits for the output register.
`default_nettype none

module modular_recurrence_nth_term_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // term_index[31:0], coef_prev[47:32], coef_third_back[63:48], addend[79:64]
    input  wire logic [79:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // term_value[13:0], zero fill [15:14]
    output logic [15:0]      m_tdata
);
    import mre_pkg::*;

    localparam int DB      = DIM_BITS;
    localparam int ENTRIES = 1 << ADDR_BITS;
    localparam int CNT_W   = 3 * DB;
    localparam logic [CNT_W-1:0] CNT_INIT_END = CNT_W'(2 * DIM * DIM - 1);
    localparam logic [CNT_W-1:0] CNT_PROD_END = CNT_W'(DIM * DIM * DIM - 1);
    localparam logic [CNT_W-1:0] CNT_RED_END  = CNT_W'(2);
    localparam logic [DB-1:0]    K_LAST       = DB'(DIM - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_RED,
        ST_RED_WAIT,
        ST_BIT,
        ST_MUL,
        ST_MUL_WAIT,
        ST_SQR,
        ST_SQR_WAIT,
        ST_FIN,
        ST_FIN_WAIT,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        SRC_MEM,
        SRC_RAW,
        SRC_FIN
    } src_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [INDEX_BITS-1:0]   ex_reg;
    logic                    acc_bank_reg, base_bank_reg;
    logic [RAW_BITS-1:0]     a_raw_reg, b_raw_reg, c_raw_reg;
    logic [RES_BITS-1:0]     c_reg;
    logic [VALUE_W-1:0]      out_value_reg;

    // output register
    logic                    m_valid_reg;
    logic [VALUE_W-1:0]      m_value_reg;
    logic                    out_load;

    // matrix store
    logic [RES_BITS-1:0]     mat_mem [ENTRIES];
    logic [RES_BITS-1:0]     rd_x_reg, rd_y_reg;

    // operand stage
    logic                    op_valid_reg;
    src_t                    op_src_reg;
    logic [OPW-1:0]          op_raw_reg;
    mac_tag_t                op_tag_reg;

    // issue side
    logic                    iss_valid;
    src_t                    iss_src;
    logic [OPW-1:0]          iss_raw;
    mac_tag_t                iss_tag;
    logic [ADDR_BITS-1:0]    rd_x_addr, rd_y_addr;

    // write side
    logic                    wr_en;
    logic [ADDR_BITS-1:0]    wr_addr;
    logic [RES_BITS-1:0]     wr_data;

    logic [INDEX_BITS-1:0]   n_in;
    logic [DB-1:0]           ci, cj, ck;
    logic [DB-1:0]           er, ec;
    logic                    init_one;

    logic [OPW-1:0]          mac_x;
    logic [RES_BITS-1:0]     mac_y;
    logic                    res_valid;
    logic [RES_BITS-1:0]     res_value;
    mac_tag_t                res_tag;
    logic                    mac_busy;
    logic                    busy;

    assign n_in = INDEX_BITS'(s_tdata[31:0]);
    assign ci   = cnt_reg[2*DB +: DB];
    assign cj   = cnt_reg[DB +: DB];
    assign ck   = cnt_reg[0 +: DB];
    assign er   = cnt_reg[DB +: DB];
    assign ec   = cnt_reg[0 +: DB];
    assign busy = op_valid_reg | mac_busy;

    // finished word moves on when the output register is free or draining
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    // initial matrix entries: identity for the power, shift rows for the base
    always_comb begin
        if (cnt_reg[2*DB]) begin
            init_one = (er == DB'(1) && ec == DB'(0)) || (er == DB'(2) && ec == DB'(1))
                    || (er == DB'(3) && ec == DB'(3)) || (er == DB'(0) && ec == DB'(3));
        end else begin
            init_one = (er == ec);
        end
    end

    // product, reduction and final scaling issue
    always_comb begin
        iss_valid     = 1'b0;
        iss_src       = SRC_MEM;
        iss_raw       = '0;
        iss_tag.first = 1'b1;
        iss_tag.last  = 1'b1;
        iss_tag.dest  = DEST_MEM;
        iss_tag.waddr = '0;
        rd_x_addr     = '0;
        rd_y_addr     = '0;
        unique case (state_reg)
            ST_RED: begin
                iss_valid = 1'b1;
                iss_src   = SRC_RAW;
                unique case (cnt_reg[1:0])
                    2'd0: begin
                        iss_raw       = OPW'(a_raw_reg);
                        iss_tag.waddr = {1'b1, 1'b0, DB'(0), DB'(0)};
                    end
                    2'd1: begin
                        iss_raw       = OPW'(b_raw_reg);
                        iss_tag.waddr = {1'b1, 1'b0, DB'(0), DB'(2)};
                    end
                    default: begin
                        iss_raw      = OPW'(c_raw_reg);
                        iss_tag.dest = DEST_COEF;
                    end
                endcase
            end
            ST_MUL: begin
                iss_valid     = 1'b1;
                iss_tag.first = (ck == '0);
                iss_tag.last  = (ck == K_LAST);
                iss_tag.waddr = {1'b0, ~acc_bank_reg, ci, cj};
                rd_x_addr     = {1'b0, acc_bank_reg, ci, ck};
                rd_y_addr     = {1'b1, base_bank_reg, ck, cj};
            end
            ST_SQR: begin
                iss_valid     = 1'b1;
                iss_tag.first = (ck == '0);
                iss_tag.last  = (ck == K_LAST);
                iss_tag.waddr = {1'b1, ~base_bank_reg, ci, cj};
                rd_x_addr     = {1'b1, base_bank_reg, ci, ck};
                rd_y_addr     = {1'b1, base_bank_reg, ck, cj};
            end
            ST_FIN: begin
                iss_valid    = 1'b1;
                iss_src      = SRC_FIN;
                iss_tag.dest = DEST_OUT;
                rd_x_addr    = {1'b0, acc_bank_reg, DB'(0), DB'(3)};
            end
            default: begin
                iss_valid = 1'b0;
            end
        endcase
    end

    // store write: setup sweep or finished matrix entry
    always_comb begin
        if (state_reg == ST_INIT) begin
            wr_en   = 1'b1;
            wr_addr = {cnt_reg[2*DB], 1'b0, cnt_reg[2*DB-1:0]};
            wr_data = RES_BITS'(init_one);
        end else begin
            wr_en   = res_valid && (res_tag.dest == DEST_MEM);
            wr_addr = res_tag.waddr;
            wr_data = res_value;
        end
    end

    // matrix store with registered reads
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mat_mem[wr_addr] <= wr_data;
        end
        rd_x_reg <= mat_mem[rd_x_addr];
        rd_y_reg <= mat_mem[rd_y_addr];
    end

    // operand stage lines up with the read data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_valid_reg <= 1'b0;
        end else begin
            op_valid_reg <= iss_valid;
        end
        op_src_reg <= iss_src;
        op_raw_reg <= iss_raw;
        op_tag_reg <= iss_tag;
    end

    // operand select
    always_comb begin
        unique case (op_src_reg)
            SRC_RAW: begin
                mac_x = op_raw_reg;
                mac_y = RES_BITS'(1);
            end
            SRC_FIN: begin
                mac_x = OPW'(rd_x_reg);
                mac_y = c_reg;
            end
            default: begin
                mac_x = OPW'(rd_x_reg);
                mac_y = rd_y_reg;
            end
        endcase
    end

    mre_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (op_valid_reg),
        .in_x      (mac_x),
        .in_y      (mac_y),
        .in_tag    (op_tag_reg),
        .res_valid (res_valid),
        .res_value (res_value),
        .res_tag   (res_tag),
        .busy      (mac_busy)
    );

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (res_valid && res_tag.dest == DEST_COEF) begin
                c_reg <= res_value;
            end
            // output register
            if (out_load) begin
                m_valid_reg <= 1'b1;
                m_value_reg <= out_value_reg;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        a_raw_reg     <= s_tdata[47:32];
                        b_raw_reg     <= s_tdata[63:48];
                        c_raw_reg     <= s_tdata[79:64];
                        ex_reg        <= n_in - INDEX_BITS'(2);
                        acc_bank_reg  <= 1'b0;
                        base_bank_reg <= 1'b0;
                        cnt_reg       <= '0;
                        if (n_in < INDEX_BITS'(3)) begin
                            out_value_reg <= '0;
                            state_reg     <= ST_OUT;
                        end else begin
                            state_reg <= ST_INIT;
                        end
                    end
                end
                ST_INIT: begin
                    if (cnt_reg == CNT_INIT_END) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_RED;
                    end else begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_RED: begin
                    if (cnt_reg == CNT_RED_END) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_RED_WAIT;
                    end else begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_RED_WAIT: begin
                    if (!busy) begin
                        state_reg <= ST_BIT;
                    end
                end
                ST_BIT: begin
                    cnt_reg <= '0;
                    if (ex_reg == '0) begin
                        state_reg <= ST_FIN;
                    end else if (ex_reg[0]) begin
                        state_reg <= ST_MUL;
                    end else begin
                        state_reg <= ST_SQR;
                    end
                end
                ST_MUL: begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_PROD_END) begin
                        state_reg <= ST_MUL_WAIT;
                    end
                end
                ST_MUL_WAIT: begin
                    if (!busy) begin
                        acc_bank_reg <= ~acc_bank_reg;
                        cnt_reg      <= '0;
                        state_reg    <= ST_SQR;
                    end
                end
                ST_SQR: begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_PROD_END) begin
                        state_reg <= ST_SQR_WAIT;
                    end
                end
                ST_SQR_WAIT: begin
                    if (!busy) begin
                        base_bank_reg <= ~base_bank_reg;
                        ex_reg        <= ex_reg >> 1;
                        state_reg     <= ST_BIT;
                    end
                end
                ST_FIN: begin
                    state_reg <= ST_FIN_WAIT;
                end
                ST_FIN_WAIT: begin
                    if (res_valid && res_tag.dest == DEST_OUT) begin
                        out_value_reg <= VALUE_W'(res_value);
                        state_reg     <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = 16'(m_value_reg);

endmodule

`default_nettype wire

>>> src/mre_mac.sv
// ============================================================================
// mre_mac: pipelined modular multiply-accumulate
// Takes one product per cycle, reduces it by a reciprocal estimate with one
// corrective subtract and folds it into a running sum; the sum is handed out
// on the product that is tagged last.
// ============================================================================
`default_nettype none

module mre_mac (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    input  wire logic [mre_pkg::OPW-1:0]      in_x,
    input  wire logic [mre_pkg::RES_BITS-1:0] in_y,
    input  wire mre_pkg::mac_tag_t            in_tag,
    output logic                             res_valid,
    output logic [mre_pkg::RES_BITS-1:0]      res_value,
    output mre_pkg::mac_tag_t                 res_tag,
    output logic                             busy
);
    import mre_pkg::*;

    // product width and reciprocal of the modulus
    localparam int PB = OPW + RES_BITS;
    localparam int RW = PB - RES_BITS + 2;
    localparam logic [63:0]   RECIP_FULL = (64'd1 << PB) / 64'(MODULUS);
    localparam logic [RW-1:0] RECIP      = RW'(RECIP_FULL);
    localparam logic [RES_BITS:0] MOD_EXT = (RES_BITS+1)'(MODULUS);

    logic                  v1_reg, v2_reg, v3_reg;
    mac_tag_t              tag1_reg, tag2_reg, tag3_reg;
    logic [PB-1:0]         p1_reg, p2_reg;
    logic [RW-1:0]         q_reg;
    logic [RES_BITS:0]     t_reg;
    logic [RES_BITS-1:0]   acc_reg;
    logic                  res_valid_reg;
    logic [RES_BITS-1:0]   res_value_reg;
    mac_tag_t              res_tag_reg;

    logic [PB-1:0]         prod;
    logic [PB+RW-1:0]      qprod;
    logic [PB-1:0]         qm;
    logic [PB-1:0]         t_full;
    logic [RES_BITS:0]     r_ext;
    logic [RES_BITS-1:0]   r;
    logic [RES_BITS:0]     sum;
    logic [RES_BITS-1:0]   sum_mod;

    // stage arithmetic
    always_comb begin
        prod    = PB'(in_x) * PB'(in_y);
        qprod   = (PB+RW)'(p1_reg) * (PB+RW)'(RECIP);
        qm      = PB'(q_reg) * PB'(MODULUS);
        t_full  = p2_reg - qm;
        r_ext   = (t_reg >= MOD_EXT) ? (t_reg - MOD_EXT) : t_reg;
        r       = r_ext[RES_BITS-1:0];
        sum     = (tag3_reg.first ? '0 : {1'b0, acc_reg}) + {1'b0, r};
        sum_mod = (sum >= MOD_EXT) ? RES_BITS'(sum - MOD_EXT) : sum[RES_BITS-1:0];
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            res_valid_reg <= v3_reg & tag3_reg.last;
        end
    end

    // datapath stages and accumulator
    always_ff @(posedge aclk) begin
        p1_reg   <= prod;
        tag1_reg <= in_tag;
        q_reg    <= qprod[PB +: RW];
        p2_reg   <= p1_reg;
        tag2_reg <= tag1_reg;
        t_reg    <= t_full[RES_BITS:0];
        tag3_reg <= tag2_reg;
        if (v3_reg) begin
            acc_reg <= sum_mod;
        end
        res_value_reg <= sum_mod;
        res_tag_reg   <= tag3_reg;
    end

    assign res_valid = res_valid_reg;
    assign res_value = res_value_reg;
    assign res_tag   = res_tag_reg;
    assign busy      = v1_reg | v2_reg | v3_reg | res_valid_reg;

endmodule

`default_nettype wire
